### hw/rtl/sprite_model_to_ndc_transform_assert.svh
// ----------------------------------------------------------------------------
// sprite model-to-ndc transform assertion macros
// concurrent checks on clk, disabled while rst_n is low; empty in synthesis
// ----------------------------------------------------------------------------
`ifndef SPRITE_MODEL_TO_NDC_TRANSFORM_ASSERT_SVH
`define SPRITE_MODEL_TO_NDC_TRANSFORM_ASSERT_SVH
`ifndef SYNTHESIS
`define SMN_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("sprite transform check failed");
`define SMN_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sprite transform check failed");
`else
`define SMN_ASSERT(lbl, expr)
`define SMN_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

### hw/rtl/sm2ndc_pkg.sv
// ----------------------------------------------------------------------------
// sm2ndc_pkg
// shared constants, register indices and helpers of the sprite transform
// ----------------------------------------------------------------------------
`default_nettype none

package sm2ndc_pkg;

    localparam int SINE_TABLE_DEPTH_DEF = 1024;

    typedef enum logic [2:0] {
        REG_SCALE_X   = 3'd0,
        REG_SCALE_Y   = 3'd1,
        REG_POS_X     = 3'd2,
        REG_POS_Y     = 3'd3,
        REG_SPIN_RATE = 3'd4
    } cfg_reg_t;

    localparam logic signed [31:0] SCALE_X_RST   = 32'sd3276800;
    localparam logic signed [31:0] SCALE_Y_RST   = 32'sd3276800;
    localparam logic signed [31:0] POS_X_RST     = 32'sd6553600;
    localparam logic signed [31:0] POS_Y_RST     = 32'sd6553600;
    localparam logic signed [31:0] SPIN_RATE_RST = 32'sd655360;

    // 360 degrees in q9.16
    localparam logic [24:0] FULL_TURN_Q16   = 25'd23592960;
    // 128 full turns, lifts any angle sum above zero
    localparam logic [33:0] TURN_OFFSET     = 34'd3019898880;
    localparam logic [25:0] DEG_TURN        = 26'd360;
    // floor(2^33 / 360)
    localparam logic [24:0] RECIP_360       = 25'd23860929;
    localparam logic [63:0] PI_Q29          = 64'd1686629713;
    localparam logic [16:0] ONE_Q16         = 17'd65536;

    function automatic logic signed [31:0] sat_q16(input logic signed [51:0] v);
        if (v > 52'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        else if (v < -52'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/sprite_model_to_ndc_transform.sv
// ----------------------------------------------------------------------------
// sprite_model_to_ndc_transform
// one item at a time: a new input beat is accepted only while the sequencer is idle,
// and every product goes through the single shared 33x33 multiplier
// the result register holds until taken; a new item waits before its matrix pass
// reset: angle to zero degrees, registers to their defaults, no result pending
// ----------------------------------------------------------------------------
`default_nettype none

`include "sprite_model_to_ndc_transform_assert.svh"

module sprite_model_to_ndc_transform #(
    parameter int SINE_TABLE_DEPTH = sm2ndc_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,

    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [15:0]        frame_time,
    input  wire logic signed [31:0] w_r0_c0,
    input  wire logic signed [31:0] w_r0_c1,
    input  wire logic signed [31:0] w_r0_c2,
    input  wire logic signed [31:0] w_r1_c0,
    input  wire logic signed [31:0] w_r1_c1,
    input  wire logic signed [31:0] w_r1_c2,
    input  wire logic signed [31:0] w_r2_c0,
    input  wire logic signed [31:0] w_r2_c1,
    input  wire logic signed [31:0] w_r2_c2,

    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      m_r0_c0,
    output logic signed [31:0]      m_r0_c1,
    output logic signed [31:0]      m_r0_c2,
    output logic signed [31:0]      m_r1_c0,
    output logic signed [31:0]      m_r1_c1,
    output logic signed [31:0]      m_r1_c2,
    output logic signed [31:0]      m_r2_c0,
    output logic signed [31:0]      m_r2_c1,
    output logic signed [31:0]      m_r2_c2
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH);
    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PW = $clog2(4 * SINE_TABLE_DEPTH);
    localparam logic [IW-1:0] DEPTH_I = IW'(SINE_TABLE_DEPTH);
    localparam logic [PW-1:0] PH_Q1 = PW'(SINE_TABLE_DEPTH);
    localparam logic [PW-1:0] PH_Q2 = PW'(2 * SINE_TABLE_DEPTH);
    localparam logic [PW-1:0] PH_Q3 = PW'(3 * SINE_TABLE_DEPTH);
    localparam logic signed [32:0] PHASE_MUL = 33'(4 * SINE_TABLE_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ANG,
        ST_WRAP,
        ST_DIVA,
        ST_DIVB,
        ST_DIVC,
        ST_DIVD,
        ST_PH,
        ST_PHB,
        ST_QUAD,
        ST_RS,
        ST_RC,
        ST_RW,
        ST_L0,
        ST_L1,
        ST_L2,
        ST_L3,
        ST_L4,
        ST_WAITO,
        ST_M,
        ST_MLAST
    } state_t;

    // quarter-wave sine, taylor series to the x^17 term in q2.30, rounded to q1.16 entries
    function automatic logic [16:0] sine_entry(input int i);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        x    = (sm2ndc_pkg::PI_Q29 * 64'(i)) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 210;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 272;
        sum  = sum + signed'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        r = (sum + 64'sd8192) >>> 14;
        if (r > 64'sd65536)
        begin
            r = 64'sd65536;
        end
        return r[16:0];
    endfunction

    logic [16:0] sine_rom [SINE_TABLE_DEPTH];

    for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++)
    begin : g_rom
        assign sine_rom[gi] = sine_entry(gi);
    end

    // control and configuration
    state_t             state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] scale_x_reg, scale_x_next;
    logic signed [31:0] scale_y_reg, scale_y_next;
    logic signed [31:0] pos_x_reg, pos_x_next;
    logic signed [31:0] pos_y_reg, pos_y_next;
    logic signed [31:0] spin_reg, spin_next;
    logic [24:0]        angle_reg, angle_next;
    logic               div_for_phase_reg, div_for_phase_next;
    logic [1:0]         mrow_reg, mrow_next;
    logic [1:0]         mcol_reg, mcol_next;
    logic               mterm_reg, mterm_next;
    logic [1:0]         mrow_d_reg, mrow_d_next;
    logic [1:0]         mcol_d_reg, mcol_d_next;
    logic               mterm_d_reg, mterm_d_next;
    logic               cvalid_reg, cvalid_next;
    logic signed [31:0] m_reg [9];
    logic signed [31:0] m_next [9];

    // datapath
    logic [15:0]        ft_reg;
    logic signed [31:0] w_reg [9];
    logic signed [65:0] prod_reg;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic [15:0]        tlo_reg, tlo_next;
    logic [24:0]        div_u_reg, div_u_next;
    logic [16:0]        est_reg, est_next;
    logic [PW-1:0]      phase_reg, phase_next;
    logic [IW-1:0]      sin_idx_reg, sin_idx_next;
    logic [IW-1:0]      cos_idx_reg, cos_idx_next;
    logic               sneg_reg, sneg_next;
    logic               cneg_reg, cneg_next;
    logic [AW-1:0]      rom_addr;
    logic               rom_full;
    logic [16:0]        rom_q_reg;
    logic               rom_full_reg;
    logic signed [17:0] s_reg, s_next;
    logic signed [17:0] c_reg, c_next;
    logic signed [31:0] l00_reg, l00_next;
    logic signed [31:0] l01_reg, l01_next;
    logic signed [31:0] l10_reg, l10_next;
    logic signed [31:0] l11_reg, l11_next;
    logic signed [51:0] acc_reg, acc_next;

    logic               in_beat;
    logic [IW-1:0]      rd_idx;
    logic signed [31:0] delta;
    logic [33:0]        turn_sum;
    logic [25:0]        div_rem;
    logic [25:0]        div_rem_fix;
    logic [16:0]        div_q_fix;
    logic [1:0]         quad;
    logic [PW-1:0]      quad_base;
    logic [PW-1:0]      j_p;
    logic [IW-1:0]      j_i;
    logic signed [17:0] rom_mag;
    logic signed [17:0] rom_val;
    logic               rom_neg;
    logic signed [33:0] l_prod;
    logic signed [49:0] m_prod;
    logic signed [31:0] l_sel;
    logic [3:0]         w_issue_idx;
    logic [3:0]         w_last_idx;
    logic [3:0]         m_idx;
    logic signed [51:0] m_sum;

    assign in_beat   = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    assign m_r0_c0 = m_reg[0];
    assign m_r0_c1 = m_reg[1];
    assign m_r0_c2 = m_reg[2];
    assign m_r1_c0 = m_reg[3];
    assign m_r1_c1 = m_reg[4];
    assign m_r1_c2 = m_reg[5];
    assign m_r2_c0 = m_reg[6];
    assign m_r2_c1 = m_reg[7];
    assign m_r2_c2 = m_reg[8];

    // product views
    assign delta    = prod_reg[47:16];
    assign turn_sum = {9'b0, angle_reg} + {{2{delta[31]}}, delta} + sm2ndc_pkg::TURN_OFFSET;
    assign l_prod   = prod_reg[49:16];
    assign m_prod   = prod_reg[65:16];

    // divide by 360 correction
    assign div_rem     = {1'b0, div_u_reg} - prod_reg[25:0];
    assign div_rem_fix = (div_rem >= sm2ndc_pkg::DEG_TURN) ?
                         (div_rem - sm2ndc_pkg::DEG_TURN) : div_rem;
    assign div_q_fix   = (div_rem >= sm2ndc_pkg::DEG_TURN) ? (est_reg + 17'd1) : est_reg;

    // quadrant split
    always_comb
    begin
        priority if (phase_reg >= PH_Q3)
        begin
            quad      = 2'd3;
            quad_base = PH_Q3;
        end
        else if (phase_reg >= PH_Q2)
        begin
            quad      = 2'd2;
            quad_base = PH_Q2;
        end
        else if (phase_reg >= PH_Q1)
        begin
            quad      = 2'd1;
            quad_base = PH_Q1;
        end
        else
        begin
            quad      = 2'd0;
            quad_base = '0;
        end
    end

    assign j_p = phase_reg - quad_base;
    assign j_i = j_p[IW-1:0];

    // table read, the last quarter point reads as one
    assign rd_idx   = (state_reg == ST_RC) ? cos_idx_reg : sin_idx_reg;
    assign rom_full = (rd_idx == DEPTH_I);
    assign rom_addr = rom_full ? '0 : rd_idx[AW-1:0];
    assign rom_mag  = rom_full_reg ? signed'({1'b0, sm2ndc_pkg::ONE_Q16})
                                   : signed'({1'b0, rom_q_reg});
    assign rom_neg  = (state_reg == ST_RC) ? sneg_reg : cneg_reg;
    assign rom_val  = rom_neg ? -rom_mag : rom_mag;

    // matrix pass selection
    assign w_issue_idx = 4'(mrow_reg) * 4'd3 + 4'(mterm_reg);
    assign w_last_idx  = 4'(mrow_d_reg) * 4'd3 + 4'd2;
    assign m_idx       = 4'(mrow_d_reg) * 4'd3 + 4'(mcol_d_reg);
    assign m_sum       = acc_reg + {{2{m_prod[49]}}, m_prod};

    always_comb
    begin
        unique case ({mterm_reg, mcol_reg})
            3'b0_00: l_sel = l00_reg;
            3'b1_00: l_sel = l10_reg;
            3'b0_01: l_sel = l01_reg;
            3'b1_01: l_sel = l11_reg;
            3'b0_10: l_sel = pos_x_reg;
            3'b1_10: l_sel = pos_y_reg;
            default: l_sel = '0;
        endcase
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_ANG:
            begin
                mul_a = {spin_reg[31], spin_reg};
                mul_b = {17'b0, ft_reg};
            end
            ST_DIVA:
            begin
                mul_a = {8'b0, div_u_reg};
                mul_b = {8'b0, sm2ndc_pkg::RECIP_360};
            end
            ST_DIVC:
            begin
                mul_a = {16'b0, est_reg};
                mul_b = {7'b0, sm2ndc_pkg::DEG_TURN};
            end
            ST_PH:
            begin
                mul_a = {8'b0, angle_reg};
                mul_b = PHASE_MUL;
            end
            ST_L0:
            begin
                mul_a = {scale_x_reg[31], scale_x_reg};
                mul_b = {{15{c_reg[17]}}, c_reg};
            end
            ST_L1:
            begin
                mul_a = {scale_y_reg[31], scale_y_reg};
                mul_b = -{{15{s_reg[17]}}, s_reg};
            end
            ST_L2:
            begin
                mul_a = {scale_x_reg[31], scale_x_reg};
                mul_b = {{15{s_reg[17]}}, s_reg};
            end
            ST_L3:
            begin
                mul_a = {scale_y_reg[31], scale_y_reg};
                mul_b = {{15{c_reg[17]}}, c_reg};
            end
            ST_M:
            begin
                mul_a = {w_reg[w_issue_idx][31], w_reg[w_issue_idx]};
                mul_b = {l_sel[31], l_sel};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next         = state_reg;
        out_valid_next     = out_valid_reg;
        scale_x_next       = scale_x_reg;
        scale_y_next       = scale_y_reg;
        pos_x_next         = pos_x_reg;
        pos_y_next         = pos_y_reg;
        spin_next          = spin_reg;
        angle_next         = angle_reg;
        div_for_phase_next = div_for_phase_reg;
        mrow_next          = mrow_reg;
        mcol_next          = mcol_reg;
        mterm_next         = mterm_reg;
        mrow_d_next        = mrow_d_reg;
        mcol_d_next        = mcol_d_reg;
        mterm_d_next       = mterm_d_reg;
        cvalid_next        = cvalid_reg;
        m_next             = m_reg;
        tlo_next           = tlo_reg;
        div_u_next         = div_u_reg;
        est_next           = est_reg;
        phase_next         = phase_reg;
        sin_idx_next       = sin_idx_reg;
        cos_idx_next       = cos_idx_reg;
        sneg_next          = sneg_reg;
        cneg_next          = cneg_reg;
        s_next             = s_reg;
        c_next             = c_reg;
        l00_next           = l00_reg;
        l01_next           = l01_reg;
        l10_next           = l10_reg;
        l11_next           = l11_reg;
        acc_next           = acc_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sm2ndc_pkg::REG_SCALE_X:   scale_x_next = cfg_data;
                sm2ndc_pkg::REG_SCALE_Y:   scale_y_next = cfg_data;
                sm2ndc_pkg::REG_POS_X:     pos_x_next   = cfg_data;
                sm2ndc_pkg::REG_POS_Y:     pos_y_next   = cfg_data;
                sm2ndc_pkg::REG_SPIN_RATE: spin_next    = cfg_data;
                default:                   ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = ST_ANG;
                end
            end
            ST_ANG:
            begin
                state_next = ST_WRAP;
            end
            ST_WRAP:
            begin
                tlo_next           = turn_sum[15:0];
                div_u_next         = {8'b0, turn_sum[32:16]};
                div_for_phase_next = 1'b0;
                state_next         = ST_DIVA;
            end
            ST_DIVA:
            begin
                state_next = ST_DIVB;
            end
            ST_DIVB:
            begin
                est_next   = prod_reg[49:33];
                state_next = ST_DIVC;
            end
            ST_DIVC:
            begin
                state_next = ST_DIVD;
            end
            ST_DIVD:
            begin
                if (div_for_phase_reg)
                begin
                    phase_next = div_q_fix[PW-1:0];
                    state_next = ST_QUAD;
                end
                else
                begin
                    angle_next = {div_rem_fix[8:0], tlo_reg};
                    state_next = ST_PH;
                end
            end
            ST_PH:
            begin
                state_next = ST_PHB;
            end
            ST_PHB:
            begin
                div_u_next         = prod_reg[40:16];
                div_for_phase_next = 1'b1;
                state_next         = ST_DIVA;
            end
            ST_QUAD:
            begin
                sin_idx_next = quad[0] ? (DEPTH_I - j_i) : j_i;
                cos_idx_next = quad[0] ? j_i : (DEPTH_I - j_i);
                sneg_next    = quad[1];
                cneg_next    = quad[1] ^ quad[0];
                state_next   = ST_RS;
            end
            ST_RS:
            begin
                state_next = ST_RC;
            end
            ST_RC:
            begin
                s_next     = rom_val;
                state_next = ST_RW;
            end
            ST_RW:
            begin
                c_next     = rom_val;
                state_next = ST_L0;
            end
            ST_L0:
            begin
                state_next = ST_L1;
            end
            ST_L1:
            begin
                l00_next   = sm2ndc_pkg::sat_q16({{18{l_prod[33]}}, l_prod});
                state_next = ST_L2;
            end
            ST_L2:
            begin
                l01_next   = sm2ndc_pkg::sat_q16({{18{l_prod[33]}}, l_prod});
                state_next = ST_L3;
            end
            ST_L3:
            begin
                l10_next   = sm2ndc_pkg::sat_q16({{18{l_prod[33]}}, l_prod});
                state_next = ST_L4;
            end
            ST_L4:
            begin
                l11_next   = sm2ndc_pkg::sat_q16({{18{l_prod[33]}}, l_prod});
                state_next = ST_WAITO;
            end
            ST_WAITO:
            begin
                if (!out_valid_reg)
                begin
                    mrow_next   = '0;
                    mcol_next   = '0;
                    mterm_next  = 1'b0;
                    cvalid_next = 1'b0;
                    state_next  = ST_M;
                end
            end
            ST_M, ST_MLAST:
            begin
                // retire the product issued last cycle
                if (cvalid_reg)
                begin
                    if (!mterm_d_reg)
                    begin
                        acc_next = {{2{m_prod[49]}}, m_prod};
                        if (mcol_d_reg == 2'd2)
                        begin
                            acc_next = {{2{m_prod[49]}}, m_prod}
                                     + {{20{w_reg[w_last_idx][31]}}, w_reg[w_last_idx]};
                        end
                    end
                    else
                    begin
                        m_next[m_idx] = sm2ndc_pkg::sat_q16(m_sum);
                    end
                end
                if (state_reg == ST_MLAST)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    mrow_d_next  = mrow_reg;
                    mcol_d_next  = mcol_reg;
                    mterm_d_next = mterm_reg;
                    cvalid_next  = 1'b1;
                    mterm_next   = ~mterm_reg;
                    if (mterm_reg)
                    begin
                        if (mcol_reg == 2'd2)
                        begin
                            mcol_next = '0;
                            if (mrow_reg == 2'd2)
                            begin
                                state_next = ST_MLAST;
                            end
                            else
                            begin
                                mrow_next = mrow_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            mcol_next = mcol_reg + 2'd1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
            scale_x_reg       <= sm2ndc_pkg::SCALE_X_RST;
            scale_y_reg       <= sm2ndc_pkg::SCALE_Y_RST;
            pos_x_reg         <= sm2ndc_pkg::POS_X_RST;
            pos_y_reg         <= sm2ndc_pkg::POS_Y_RST;
            spin_reg          <= sm2ndc_pkg::SPIN_RATE_RST;
            angle_reg         <= '0;
            div_for_phase_reg <= 1'b0;
            mrow_reg          <= '0;
            mcol_reg          <= '0;
            mterm_reg         <= 1'b0;
            mrow_d_reg        <= '0;
            mcol_d_reg        <= '0;
            mterm_d_reg       <= 1'b0;
            cvalid_reg        <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                m_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg         <= state_next;
            out_valid_reg     <= out_valid_next;
            scale_x_reg       <= scale_x_next;
            scale_y_reg       <= scale_y_next;
            pos_x_reg         <= pos_x_next;
            pos_y_reg         <= pos_y_next;
            spin_reg          <= spin_next;
            angle_reg         <= angle_next;
            div_for_phase_reg <= div_for_phase_next;
            mrow_reg          <= mrow_next;
            mcol_reg          <= mcol_next;
            mterm_reg         <= mterm_next;
            mrow_d_reg        <= mrow_d_next;
            mcol_d_reg        <= mcol_d_next;
            mterm_d_reg       <= mterm_d_next;
            cvalid_reg        <= cvalid_next;
            m_reg             <= m_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            ft_reg   <= frame_time;
            w_reg[0] <= w_r0_c0;
            w_reg[1] <= w_r0_c1;
            w_reg[2] <= w_r0_c2;
            w_reg[3] <= w_r1_c0;
            w_reg[4] <= w_r1_c1;
            w_reg[5] <= w_r1_c2;
            w_reg[6] <= w_r2_c0;
            w_reg[7] <= w_r2_c1;
            w_reg[8] <= w_r2_c2;
        end
        prod_reg     <= mul_a * mul_b;
        tlo_reg      <= tlo_next;
        div_u_reg    <= div_u_next;
        est_reg      <= est_next;
        phase_reg    <= phase_next;
        sin_idx_reg  <= sin_idx_next;
        cos_idx_reg  <= cos_idx_next;
        sneg_reg     <= sneg_next;
        cneg_reg     <= cneg_next;
        rom_q_reg    <= sine_rom[rom_addr];
        rom_full_reg <= rom_full;
        s_reg        <= s_next;
        c_reg        <= c_next;
        l00_reg      <= l00_next;
        l01_reg      <= l01_next;
        l10_reg      <= l10_next;
        l11_reg      <= l11_next;
        acc_reg      <= acc_next;
    end

    `SMN_ASSERT(a_angle_in_turn, angle_reg < sm2ndc_pkg::FULL_TURN_Q16)
    `SMN_ASSERT_IMP(a_div_rem_range, state_reg == ST_DIVD, div_rem_fix < sm2ndc_pkg::DEG_TURN)
    `SMN_ASSERT_IMP(a_matrix_pass_free, state_reg == ST_M, !out_valid_reg)
    `SMN_ASSERT_IMP(a_result_from_pass, $rose(out_valid_reg), $past(state_reg == ST_MLAST))

endmodule

`default_nettype wire
